// ----- sv/servo_pkg.sv -----
// Shared types, field widths, codes and defaults of the servo pulse generator.
package servo_pkg;

   // Field widths of the input and result items.
   localparam int KIND_W      = 2;
   localparam int CHANNEL_W   = 3;
   localparam int VALUE_W     = 16;
   localparam int LEVELS_W    = 8;
   localparam int WIDTH_W     = 12;
   localparam int ANGLE_W     = 8;
   localparam int COUNTER_W   = 16;
   localparam int ACTIVE_W    = 4;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   // Width of the numerators fed to the constant dividers (180 * 4095 < 2**20).
   localparam int NUM_W = 20;

   // Item kinds.
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WIDTH = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_CHANNELS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_LENGTH    = 1'd1;

   localparam int ANGLE_MAX = 180;

   // Reset values and parameter defaults.
   localparam logic [ACTIVE_W-1:0]  ACTIVE_RESET = 4'd0;
   localparam logic [COUNTER_W-1:0] FRAME_RESET  = 16'd20000;
   localparam int CHANNELS_DEFAULT      = 8;
   localparam int MIN_PULSE_DEFAULT     = 544;
   localparam int MAX_PULSE_DEFAULT     = 2400;
   localparam int DEFAULT_PULSE_DEFAULT = 1500;

   // Item tag that travels alongside the pipeline payload.
   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [CHANNEL_W-1:0] channel;
   } item_meta_type;

endpackage

// ----- sv/servo_width_unit.sv -----
// Two-stage conversion of a set item into the pulse width that it would store.
module servo_width_unit
   import servo_pkg::*;
#(
   parameter int MIN_PULSE = MIN_PULSE_DEFAULT,
   parameter int MAX_PULSE = MAX_PULSE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  item_meta_type        in_meta,
   input  logic [VALUE_W-1:0]   in_value,
   output logic                 out_valid,
   input  logic                 out_ready,
   output item_meta_type        out_meta,
   output logic [WIDTH_W-1:0]   out_width
);

   localparam int SPAN     = MAX_PULSE - MIN_PULSE;
   localparam int SPAN_ABS = (SPAN < 0) ? -SPAN : SPAN;
   localparam bit SPAN_NEG = (SPAN < 0);
   localparam logic [WIDTH_W-1:0] SPAN_ABS_W = WIDTH_W'(SPAN_ABS);

   // Division by 180 as a multiplication by a rounded-up reciprocal; exact for
   // every numerator below 2**NUM_W.
   localparam int DIV_SHIFT = NUM_W + $clog2(ANGLE_MAX);
   localparam int PROD_W    = DIV_SHIFT + NUM_W;
   localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + 64'(ANGLE_MAX) - 64'd1) / 64'(ANGLE_MAX);
   localparam logic [PROD_W-1:0] DIV_RECIP_W = PROD_W'(DIV_RECIP);

   localparam int SUM_W = WIDTH_W + 2;
   localparam logic signed [SUM_W-1:0] MIN_S = SUM_W'(MIN_PULSE);
   localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'(MAX_PULSE);
   localparam logic [VALUE_W-1:0] MIN_V = VALUE_W'(MIN_PULSE);
   localparam logic [VALUE_W-1:0] MAX_V = VALUE_W'(MAX_PULSE);

   logic                s1_valid_ff;
   logic                s1_ready;
   item_meta_type       s1_meta_ff;
   logic [NUM_W-1:0]    s1_prod_ff;
   logic [NUM_W-1:0]    s1_prod_in;
   logic [WIDTH_W-1:0]  s1_clamp_ff;
   logic [WIDTH_W-1:0]  s1_clamp_in;
   logic [ANGLE_W-1:0]  angle_sat;
   logic [VALUE_W-1:0]  value_lo;
   logic [VALUE_W-1:0]  value_hi;

   logic                s2_valid_ff;
   logic                s2_ready;
   item_meta_type       s2_meta_ff;
   logic [WIDTH_W-1:0]  s2_width_ff;
   logic [WIDTH_W-1:0]  s2_width_in;
   logic [PROD_W-1:0]   quot_prod;
   logic [WIDTH_W-1:0]  quot;
   logic signed [SUM_W-1:0] width_sum;
   logic signed [SUM_W-1:0] width_lo;
   logic signed [SUM_W-1:0] width_hi;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage one: saturate the angle and scale it by the span; clamp a raw width.
   always_comb begin
      angle_sat   = (in_value > VALUE_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : in_value[ANGLE_W-1:0];
      s1_prod_in  = NUM_W'(angle_sat) * NUM_W'(SPAN_ABS_W);
      value_lo    = (in_value < MIN_V) ? MIN_V : in_value;
      value_hi    = (value_lo > MAX_V) ? MAX_V : value_lo;
      s1_clamp_in = value_hi[WIDTH_W-1:0];
   end

   // Stage two: divide by 180, offset by the minimum pulse and clamp.
   always_comb begin
      quot_prod = PROD_W'(s1_prod_ff) * DIV_RECIP_W;
      quot      = quot_prod[DIV_SHIFT +: WIDTH_W];
      if (SPAN_NEG) begin
         width_sum = MIN_S - $signed({2'b00, quot});
      end else begin
         width_sum = MIN_S + $signed({2'b00, quot});
      end
      width_lo = (width_sum < MIN_S) ? MIN_S : width_sum;
      width_hi = (width_lo > MAX_S) ? MAX_S : width_lo;
      if (s1_meta_ff.kind == KIND_ANGLE) begin
         s2_width_in = width_hi[WIDTH_W-1:0];
      end else begin
         s2_width_in = s1_clamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_meta_ff  <= in_meta;
         s1_prod_ff  <= s1_prod_in;
         s1_clamp_ff <= s1_clamp_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_meta_ff  <= s1_meta_ff;
         s2_width_ff <= s2_width_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_meta  = s2_meta_ff;
   assign out_width = s2_width_ff;

endmodule

// ----- sv/servo_angle_unit.sv -----
// Two-stage conversion of a pulse width back into a truncated angle.
module servo_angle_unit
   import servo_pkg::*;
#(
   parameter int MIN_PULSE = MIN_PULSE_DEFAULT,
   parameter int MAX_PULSE = MAX_PULSE_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  item_meta_type        in_meta,
   input  logic [WIDTH_W-1:0]   in_width,
   output logic                 out_valid,
   input  logic                 out_ready,
   output item_meta_type        out_meta,
   output logic [WIDTH_W-1:0]   out_width,
   output logic [ANGLE_W-1:0]   out_angle
);

   localparam int SPAN      = MAX_PULSE - MIN_PULSE;
   localparam int SPAN_ABS  = (SPAN < 0) ? -SPAN : SPAN;
   localparam bit SPAN_NEG  = (SPAN < 0);
   localparam bit SPAN_ZERO = (SPAN == 0);
   localparam int SPAN_DIV  = SPAN_ZERO ? 1 : SPAN_ABS;

   // Division by the span through a rounded-up reciprocal, exact below 2**NUM_W.
   localparam int DIV_SHIFT = NUM_W + $clog2(SPAN_DIV);
   localparam int PROD_W    = DIV_SHIFT + NUM_W;
   localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + 64'(SPAN_DIV) - 64'd1) / 64'(SPAN_DIV);
   localparam logic [PROD_W-1:0] DIV_RECIP_W = PROD_W'(DIV_RECIP);

   localparam logic [WIDTH_W-1:0] MIN_W = WIDTH_W'(MIN_PULSE);

   logic                s1_valid_ff;
   logic                s1_ready;
   item_meta_type       s1_meta_ff;
   logic [WIDTH_W-1:0]  s1_width_ff;
   logic [NUM_W-1:0]    s1_num_ff;
   logic [NUM_W-1:0]    s1_num_in;
   logic                s1_neg_ff;
   logic                s1_neg_in;
   logic                below_min;
   logic [WIDTH_W-1:0]  diff_mag;

   logic                s2_valid_ff;
   logic                s2_ready;
   item_meta_type       s2_meta_ff;
   logic [WIDTH_W-1:0]  s2_width_ff;
   logic [ANGLE_W-1:0]  s2_angle_ff;
   logic [ANGLE_W-1:0]  s2_angle_in;
   logic [PROD_W-1:0]   quot_prod;
   logic [NUM_W-1:0]    quot;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   // Stage one: magnitude of the offset from the minimum, times 180, and the sign.
   always_comb begin
      below_min = (in_width < MIN_W);
      diff_mag  = below_min ? (MIN_W - in_width) : (in_width - MIN_W);
      s1_num_in = NUM_W'(diff_mag) * NUM_W'(ANGLE_MAX);
      s1_neg_in = below_min ^ SPAN_NEG;
   end

   // Stage two: divide by the span, cap at 180; a negative sign or zero span gives 0.
   always_comb begin
      quot_prod = PROD_W'(s1_num_ff) * DIV_RECIP_W;
      quot      = quot_prod[DIV_SHIFT +: NUM_W];
      if (SPAN_ZERO || s1_neg_ff) begin
         s2_angle_in = '0;
      end else if (quot > NUM_W'(ANGLE_MAX)) begin
         s2_angle_in = ANGLE_W'(ANGLE_MAX);
      end else begin
         s2_angle_in = quot[ANGLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && s1_ready) begin
         s1_meta_ff  <= in_meta;
         s1_width_ff <= in_width;
         s1_num_ff   <= s1_num_in;
         s1_neg_ff   <= s1_neg_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_meta_ff  <= s1_meta_ff;
         s2_width_ff <= s1_width_ff;
         s2_angle_ff <= s2_angle_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_meta  = s2_meta_ff;
   assign out_width = s2_width_ff;
   assign out_angle = s2_angle_ff;

endmodule

// ----- sv/servo_state_core.sv -----
// Frame counter, per-channel width and angle store, configuration and result register.
module servo_state_core
   import servo_pkg::*;
#(
   parameter int CHANNELS      = CHANNELS_DEFAULT,
   parameter int MIN_PULSE     = MIN_PULSE_DEFAULT,
   parameter int MAX_PULSE     = MAX_PULSE_DEFAULT,
   parameter int DEFAULT_PULSE = DEFAULT_PULSE_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  item_meta_type            in_meta,
   input  logic [WIDTH_W-1:0]       in_width,
   input  logic [ANGLE_W-1:0]       in_angle,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [LEVELS_W-1:0]      out_levels,
   output logic [WIDTH_W-1:0]       out_width,
   output logic [ANGLE_W-1:0]       out_angle
);

   localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LEVEL_CH  = (CHANNELS < LEVELS_W) ? CHANNELS : LEVELS_W;
   localparam int CH_CMP_W  = 6;

   // Angle that the default width reads back as.
   localparam int SPAN      = MAX_PULSE - MIN_PULSE;
   localparam int SPAN_DIV  = (SPAN == 0) ? 1 : SPAN;
   localparam int DEF_RAW   = (SPAN == 0) ? 0 :
                              ((DEFAULT_PULSE - MIN_PULSE) * ANGLE_MAX) / SPAN_DIV;
   localparam int DEF_ANGLE = (DEF_RAW < 0) ? 0 : ((DEF_RAW > ANGLE_MAX) ? ANGLE_MAX : DEF_RAW);
   localparam logic [WIDTH_W-1:0] DEF_WIDTH_W = WIDTH_W'(DEFAULT_PULSE);
   localparam logic [ANGLE_W-1:0] DEF_ANGLE_W = ANGLE_W'(DEF_ANGLE);

   logic [COUNTER_W-1:0]  counter_ff;
   logic [COUNTER_W-1:0]  counter_in;
   logic [ACTIVE_W-1:0]   active_ff;
   logic [COUNTER_W-1:0]  frame_ff;
   logic [WIDTH_W-1:0]    width_ff [CHANNELS];
   logic [WIDTH_W-1:0]    width_in [CHANNELS];
   logic [ANGLE_W-1:0]    angle_ff [CHANNELS];
   logic [ANGLE_W-1:0]    angle_in [CHANNELS];

   logic                  out_valid_ff;
   logic [LEVELS_W-1:0]   out_levels_ff;
   logic [LEVELS_W-1:0]   out_levels_in;
   logic [WIDTH_W-1:0]    out_width_ff;
   logic [WIDTH_W-1:0]    out_width_in;
   logic [ANGLE_W-1:0]    out_angle_ff;
   logic [ANGLE_W-1:0]    out_angle_in;

   logic                  take;
   logic                  ch_ok;
   logic                  store;
   logic [7:0]            ch_wide;
   logic [IDX_W-1:0]      idx;
   logic [COUNTER_W-1:0]  frame_len;
   logic [COUNTER_W:0]    counter_inc;

   assign in_ready  = !out_valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      ch_wide = 8'(in_meta.channel);
      idx     = ch_wide[IDX_W-1:0];
      ch_ok   = (CH_CMP_W'(in_meta.channel) < CH_CMP_W'(CHANNELS));
      store   = ch_ok && ((in_meta.kind == KIND_ANGLE) || (in_meta.kind == KIND_WIDTH));

      // A zero frame length counts as one, which pins the counter at zero.
      frame_len   = (frame_ff == '0) ? COUNTER_W'(1) : frame_ff;
      counter_inc = {1'b0, counter_ff} + (COUNTER_W + 1)'(1);
      if (in_meta.kind == KIND_TICK) begin
         if (counter_inc >= {1'b0, frame_len}) begin
            counter_in = '0;
         end else begin
            counter_in = counter_inc[COUNTER_W-1:0];
         end
      end else begin
         counter_in = counter_ff;
      end

      for (int i = 0; i < CHANNELS; i++) begin
         if (store && (idx == IDX_W'(i))) begin
            width_in[i] = in_width;
            angle_in[i] = in_angle;
         end else begin
            width_in[i] = width_ff[i];
            angle_in[i] = angle_ff[i];
         end
      end

      // Levels are taken from the state as it stands after this item.
      out_levels_in = '0;
      for (int i = 0; i < LEVEL_CH; i++) begin
         out_levels_in[i] = (ACTIVE_W'(i) < active_ff) &&
                            (counter_in < COUNTER_W'(width_in[i]));
      end

      if (ch_ok) begin
         out_width_in = width_in[idx];
         out_angle_in = angle_in[idx];
      end else begin
         out_width_in = '0;
         out_angle_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff   <= '0;
         active_ff    <= ACTIVE_RESET;
         frame_ff     <= FRAME_RESET;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            width_ff[i] <= DEF_WIDTH_W;
            angle_ff[i] <= DEF_ANGLE_W;
         end
      end else begin
         if (in_ready) begin
            out_valid_ff <= in_valid;
         end
         if (take) begin
            counter_ff <= counter_in;
            for (int i = 0; i < CHANNELS; i++) begin
               width_ff[i] <= width_in[i];
               angle_ff[i] <= angle_in[i];
            end
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_ACTIVE_CHANNELS: active_ff <= csr_data[ACTIVE_W-1:0];
               CSR_FRAME_LENGTH:    frame_ff  <= csr_data[COUNTER_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_levels_ff <= out_levels_in;
         out_width_ff  <= out_width_in;
         out_angle_ff  <= out_angle_in;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_levels = out_levels_ff;
   assign out_width  = out_width_ff;
   assign out_angle  = out_angle_ff;

endmodule

// ----- sv/multi_channel_servo_pulse_generator.sv -----
// Top level of the multi-channel servo pulse generator.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+-------------------------------------------
//  req      | in        | req_tvalid/tready    | tuser: kind; tdata: channel, value
//  rsp      | out       | rsp_tvalid/tready    | tdata: pin_levels, channel_width, angle
//  csr      | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// The block takes one request transaction per clock cycle unless a stalled result backs up
// the stages. Each item passes five register stages: two turn a set item into a pulse
// width, two more turn that width back into an angle, and the last updates the frame
// counter and channel store and loads the result register. Synchronous reset clears every
// valid flag and the counter, sets each channel to the default pulse width, and returns
// the configuration to no active channels and a 20000-tick frame. A stalled result only
// holds the stages that are full; bubbles ahead of it still fill.
module multi_channel_servo_pulse_generator
   import servo_pkg::*;
#(
   parameter int CHANNELS      = CHANNELS_DEFAULT,
   parameter int MIN_PULSE     = MIN_PULSE_DEFAULT,
   parameter int MAX_PULSE     = MAX_PULSE_DEFAULT,
   parameter int DEFAULT_PULSE = DEFAULT_PULSE_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_TDATA_W-1:0]   req_tdata,   // channel [2:0], value [18:3], zero pad
   input  logic [KIND_W-1:0]        req_tuser,   // kind [1:0]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,   // pin_levels [7:0], channel_width [19:8],
                                                 // channel_angle [27:20], zero pad
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   item_meta_type         req_meta;
   logic [VALUE_W-1:0]    req_value;

   logic                  wu_valid;
   logic                  wu_ready;
   item_meta_type         wu_meta;
   logic [WIDTH_W-1:0]    wu_width;

   logic                  au_valid;
   logic                  au_ready;
   item_meta_type         au_meta;
   logic [WIDTH_W-1:0]    au_width;
   logic [ANGLE_W-1:0]    au_angle;

   logic [LEVELS_W-1:0]   rsp_levels;
   logic [WIDTH_W-1:0]    rsp_width;
   logic [ANGLE_W-1:0]    rsp_angle;

   // Unpack the request transaction.
   assign req_meta.kind    = req_tuser;
   assign req_meta.channel = req_tdata[CHANNEL_W-1:0];
   assign req_value        = req_tdata[CHANNEL_W +: VALUE_W];

   // The width conversion runs for every item; ticks simply ignore its result.
   servo_width_unit #(
      .MIN_PULSE (MIN_PULSE),
      .MAX_PULSE (MAX_PULSE)
   ) u_width (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_meta   (req_meta),
      .in_value  (req_value),
      .out_valid (wu_valid),
      .out_ready (wu_ready),
      .out_meta  (wu_meta),
      .out_width (wu_width)
   );

   // The readback angle is computed for every item and stored with a written width.
   servo_angle_unit #(
      .MIN_PULSE (MIN_PULSE),
      .MAX_PULSE (MAX_PULSE)
   ) u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wu_valid),
      .in_ready  (wu_ready),
      .in_meta   (wu_meta),
      .in_width  (wu_width),
      .out_valid (au_valid),
      .out_ready (au_ready),
      .out_meta  (au_meta),
      .out_width (au_width),
      .out_angle (au_angle)
   );

   // All state lives here, so items see each other's effects strictly in order.
   servo_state_core #(
      .CHANNELS      (CHANNELS),
      .MIN_PULSE     (MIN_PULSE),
      .MAX_PULSE     (MAX_PULSE),
      .DEFAULT_PULSE (DEFAULT_PULSE)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (au_valid),
      .in_ready   (au_ready),
      .in_meta    (au_meta),
      .in_width   (au_width),
      .in_angle   (au_angle),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_levels (rsp_levels),
      .out_width  (rsp_width),
      .out_angle  (rsp_angle)
   );

   // Pack the result transaction.
   assign rsp_tdata = {(RSP_TDATA_W - LEVELS_W - WIDTH_W - ANGLE_W)'(0),
                       rsp_angle, rsp_width, rsp_levels};

endmodule

// ----- sv/servo_checker.sv -----
// Port-level checks of the servo pulse generator and their binding to the top level.
module servo_checker
   import servo_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RSP_TDATA_W-1:0]  rsp_tdata
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // Nothing comes out in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result offered right after reset");

   // The readback angle never passes the full swing.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[27:20] <= ANGLE_W'(ANGLE_MAX)))
      else $error("readback angle above full swing");

   // A nonzero angle belongs to an addressed channel, whose width is never zero.
   a_angle_width: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[27:20] != '0) |-> (rsp_tdata[19:8] != '0))
      else $error("angle reported without a width");

endmodule

bind multi_channel_servo_pulse_generator servo_checker u_checker (.*);
